/* src/running_sample_statistics_core_defines.svh */
// ----------------------------------------------------------------------------
// running sample statistics: assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RUNNING_SAMPLE_STATISTICS_CORE_DEFINES_SVH
`define RUNNING_SAMPLE_STATISTICS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define RSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define RSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSS_ASSERT(lbl, prop, msg)
`define RSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants, types and state encoding for the sample statistics core.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int QUEUE_DEPTH     = 2;

  localparam int SAMPLE_W    = 16;
  localparam int VARIANCE_W  = 31;
  localparam int COUNT_OUT_W = 13;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV_AVG,
    BK_DIV_MSQ,
    BK_DIV_VAR,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* src/rss_front.sv */
// ----------------------------------------------------------------------------
// rss_front
// Sample intake: squares each sample, then folds it into the running
// min, max, sum, sum of squares and count; pushes a record per closed set.
// ----------------------------------------------------------------------------
module rss_front import rss_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [15:0]      sample,
  input  logic                    last,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    q_full,
  output logic                    rec_push,
  output logic signed [15:0]      rec_min,
  output logic signed [15:0]      rec_max,
  output logic signed [17+$clog2(MAX_SAMPLES)-1:0] rec_sum,
  output logic [31+$clog2(MAX_SAMPLES)-1:0]        rec_sumsq,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]         rec_count,
  output logic                    rec_too_many
);

  localparam int LW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = 17 + LW;
  localparam int SQW = 31 + LW;
  localparam logic [CW-1:0] CNT_LIMIT = CW'(MAX_SAMPLES);

  // square stage
  logic               s1_valid;
  logic signed [15:0] s1_x;
  logic [30:0]        s1_sq;
  logic               s1_last;
  logic signed [31:0] prod;
  logic               consume;

  // running state
  logic [CW-1:0]        count;
  logic signed [15:0]   running_min;
  logic signed [15:0]   running_max;
  logic signed [SW-1:0] running_sum;
  logic [SQW-1:0]       running_sumsq;
  logic                 too_many;

  logic                 full;
  logic [CW-1:0]        count_next;
  logic signed [15:0]   running_min_next;
  logic signed [15:0]   running_max_next;
  logic signed [SW-1:0] running_sum_next;
  logic [SQW-1:0]       running_sumsq_next;
  logic                 too_many_next;

  assign prod     = sample * sample;
  assign consume  = s1_valid && (!s1_last || !q_full);
  assign in_ready = !s1_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_x    <= sample;
      s1_sq   <= prod[30:0];
      s1_last <= last;
    end
  end

  // a sample beyond the limit only marks the set as too long
  always_comb begin
    full               = (count == CNT_LIMIT);
    count_next         = count;
    running_min_next   = running_min;
    running_max_next   = running_max;
    running_sum_next   = running_sum;
    running_sumsq_next = running_sumsq;
    too_many_next      = too_many | full;
    if (!full) begin
      count_next         = count + 1'b1;
      running_sum_next   = running_sum + {{(SW-16){s1_x[15]}}, s1_x};
      running_sumsq_next = running_sumsq + {{(SQW-31){1'b0}}, s1_sq};
      if (s1_x < running_min) begin
        running_min_next = s1_x;
      end
      if (s1_x > running_max) begin
        running_max_next = s1_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      running_min   <= SAMPLE_MAX;
      running_max   <= SAMPLE_MIN;
      running_sum   <= '0;
      running_sumsq <= '0;
      too_many      <= 1'b0;
    end else if (consume) begin
      if (s1_last) begin
        count         <= '0;
        running_min   <= SAMPLE_MAX;
        running_max   <= SAMPLE_MIN;
        running_sum   <= '0;
        running_sumsq <= '0;
        too_many      <= 1'b0;
      end else begin
        count         <= count_next;
        running_min   <= running_min_next;
        running_max   <= running_max_next;
        running_sum   <= running_sum_next;
        running_sumsq <= running_sumsq_next;
        too_many      <= too_many_next;
      end
    end
  end

  assign rec_push     = consume && s1_last;
  assign rec_min      = running_min_next;
  assign rec_max      = running_max_next;
  assign rec_sum      = running_sum_next;
  assign rec_sumsq    = running_sumsq_next;
  assign rec_count    = count_next;
  assign rec_too_many = too_many_next;

endmodule

/* src/rss_fifo.sv */
// ----------------------------------------------------------------------------
// rss_fifo
// Small register queue of closed-set records between intake and back end.
// ----------------------------------------------------------------------------
module rss_fifo import rss_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign full     = (fill == NW'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* src/rss_divider.sv */
// ----------------------------------------------------------------------------
// rss_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rss_divider import rss_pkg::*; #(
  parameter int DW = 32,
  parameter int NW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output div_status_t   status,
  output logic [DW-1:0] quotient
);

  localparam int SCW = $clog2(DW + 1);

  logic [DW-1:0]  quo;
  logic [NW-1:0]  rem;
  logic [NW-1:0]  dvs;
  logic [SCW-1:0] steps;
  logic           busy;
  logic           done;
  logic [NW:0]    shifted;
  logic [NW:0]    diff;
  logic           ge;

  assign shifted = {rem, quo[DW-1]};
  assign ge      = (shifted >= {1'b0, dvs});
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= SCW'(DW);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == SCW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[NW-1:0] : shifted[NW-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

/* src/rss_back.sv */
// ----------------------------------------------------------------------------
// rss_back
// Result sequencer: takes one record, runs the mean and variance divisions
// on a shared divider and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "running_sample_statistics_core_defines.svh"

module rss_back import rss_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  output logic                    q_pop,
  input  logic signed [15:0]      rec_min,
  input  logic signed [15:0]      rec_max,
  input  logic signed [17+$clog2(MAX_SAMPLES)-1:0] rec_sum,
  input  logic [31+$clog2(MAX_SAMPLES)-1:0]        rec_sumsq,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]         rec_count,
  input  logic                    rec_too_many,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [15:0]      smallest,
  output logic signed [15:0]      largest,
  output logic signed [15:0]      average,
  output logic [VARIANCE_W-1:0]   variance,
  output logic [COUNT_OUT_W-1:0]  sample_count,
  output logic                    overflow
);

  localparam int LW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = 17 + LW;
  localparam int SQW = 31 + LW;
  localparam int MW  = SW - 1;
  localparam int DW  = 2 * MW;

  back_state_t state;
  back_state_t state_next;

  logic signed [15:0] w_min;
  logic signed [15:0] w_max;
  logic               w_neg;
  logic [MW-1:0]      w_abs;
  logic [SQW-1:0]     w_sumsq;
  logic [CW-1:0]      w_cnt;
  logic               w_tm;
  logic [DW-1:0]      sq_reg;
  logic [15:0]        avg_reg;

  logic [SW-1:0]      sum_abs;
  logic [15:0]        q_low;
  logic [CW+12:0]     cnt_wide;

  logic               div_start;
  logic [DW-1:0]      div_dividend;
  div_status_t        div_st;
  logic [DW-1:0]      div_quo;
  logic               out_load;

  assign sum_abs  = rec_sum[SW-1] ? (~rec_sum + 1'b1) : rec_sum;
  assign q_low    = div_quo[15:0];
  assign cnt_wide = {13'd0, w_cnt};

  rss_divider #(
    .DW (DW),
    .NW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (w_cnt),
    .status   (div_st),
    .quotient (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = BK_LOAD;
        end
      end
      BK_LOAD: state_next = BK_DIV_AVG;
      BK_DIV_AVG: begin
        if (div_st.done) begin
          state_next = BK_DIV_MSQ;
        end
      end
      BK_DIV_MSQ: begin
        if (div_st.done) begin
          state_next = BK_DIV_VAR;
        end
      end
      BK_DIV_VAR: begin
        if (div_st.done) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    out_load     = 1'b0;
    case (state)
      BK_IDLE: q_pop = !q_empty;
      BK_LOAD: begin
        div_start    = 1'b1;
        div_dividend = {{(DW-MW){1'b0}}, w_abs};
      end
      BK_DIV_AVG: begin
        div_start    = div_st.done;
        div_dividend = sq_reg;
      end
      BK_DIV_MSQ: begin
        // sumsq minus floor(sum^2 / n) is never negative
        div_start    = div_st.done;
        div_dividend = {{(DW-SQW){1'b0}}, w_sumsq} - div_quo;
      end
      BK_DIV_VAR: begin
      end
      BK_DONE: out_load = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_min   <= rec_min;
      w_max   <= rec_max;
      w_neg   <= rec_sum[SW-1];
      w_abs   <= sum_abs[MW-1:0];
      w_sumsq <= rec_sumsq;
      w_cnt   <= rec_count;
      w_tm    <= rec_too_many;
    end
    if (state == BK_LOAD) begin
      sq_reg <= w_abs * w_abs;
    end
    // mean truncates toward zero: divide the magnitude, restore the sign
    if (state == BK_DIV_AVG && div_st.done) begin
      avg_reg <= w_neg ? (~q_low + 16'd1) : q_low;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      smallest     <= w_min;
      largest      <= w_max;
      average      <= avg_reg;
      variance     <= div_quo[VARIANCE_W-1:0];
      sample_count <= cnt_wide[COUNT_OUT_W-1:0];
      overflow     <= w_tm;
    end
  end

  `RSS_ASSERT(a_start_not_busy, div_start |-> !div_st.busy, "divider restarted mid-division")
  `RSS_ASSERT(a_load_free, out_load |-> (!out_valid || out_ready), "result register overwritten")
  `RSS_ASSERT_ALWAYS(a_idle_quiet, (state == BK_IDLE) |-> !div_st.busy, "divider busy while idle")

endmodule

/* src/running_sample_statistics_core.sv */
// ----------------------------------------------------------------------------
// running_sample_statistics_core
// Running min, max, mean and variance over sets of signed 16-bit samples.
// ----------------------------------------------------------------------------
// Usage: samples enter on sample/last with in_valid/in_ready, one request per
// cycle while in_ready is high; last closes the set. For each closed set one
// result leaves on out_valid/out_ready: minimum, maximum, mean and variance
// (both truncated toward zero), count (saturating at MAX_SAMPLES) and an
// overflow flag. Samples past MAX_SAMPLES only set overflow; the last one
// still closes. Intake squares a sample, then accumulates it; it takes a
// sample every cycle as long as the record queue (QUEUE_DEPTH sets) has room.
// The back end works on one set at a time with a shared bit-serial divider
// of DW = 2*(16+clog2(MAX_SAMPLES)) bits; it runs the mean, sum^2/n and
// variance divisions in turn and takes the next set only after its result
// is loaded into the output register.
// Reset empties the queue and clears the running state; no result is
// pending after it. A stalled receiver holds the result register, the back
// end waits with the next set done, then the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
module running_sample_statistics_core import rss_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic signed [15:0]     sample,
  input  logic                   last,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic signed [15:0]     smallest,
  output logic signed [15:0]     largest,
  output logic signed [15:0]     average,
  output logic [VARIANCE_W-1:0]  variance,
  output logic [COUNT_OUT_W-1:0] sample_count,
  output logic                   overflow,
  output logic                   out_valid,
  input  logic                   out_ready
);

  localparam int LW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = 17 + LW;
  localparam int SQW = 31 + LW;
  localparam int RW  = 1 + CW + SQW + SW + 32;

  logic                 f_push;
  logic signed [15:0]   f_min;
  logic signed [15:0]   f_max;
  logic signed [SW-1:0] f_sum;
  logic [SQW-1:0]       f_sumsq;
  logic [CW-1:0]        f_count;
  logic                 f_tm;

  logic [RW-1:0]        q_in;
  logic [RW-1:0]        q_out;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;

  rss_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .last         (last),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .q_full       (q_full),
    .rec_push     (f_push),
    .rec_min      (f_min),
    .rec_max      (f_max),
    .rec_sum      (f_sum),
    .rec_sumsq    (f_sumsq),
    .rec_count    (f_count),
    .rec_too_many (f_tm)
  );

  assign q_in = {f_tm, f_count, f_sumsq, f_sum, f_max, f_min};

  rss_fifo #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  rss_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .rec_min      (q_out[15:0]),
    .rec_max      (q_out[31:16]),
    .rec_sum      (q_out[SW+31:32]),
    .rec_sumsq    (q_out[SQW+SW+31:SW+32]),
    .rec_count    (q_out[CW+SQW+SW+31:SQW+SW+32]),
    .rec_too_many (q_out[RW-1]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .smallest     (smallest),
    .largest      (largest),
    .average      (average),
    .variance     (variance),
    .sample_count (sample_count),
    .overflow     (overflow)
  );

endmodule
